// ===== hw/rtl/rsaw_pkg.sv =====
`timescale 1ns / 1ps

package rsaw_pkg;

    // Receive window depth (pending map bits beyond the last delivered sequence)
    localparam int HOLD_WINDOW = 32;
    localparam int IDX_W       = $clog2(HOLD_WINDOW);
    localparam int SEQ_W       = 16;
    localparam int ACK_W       = 32;

    localparam logic signed [SEQ_W-1:0] HOLD_WINDOW_S = SEQ_W'(HOLD_WINDOW);
    localparam logic signed [SEQ_W-1:0] TOO_OLD_S     = -SEQ_W'(32);

    // Status codes
    localparam logic [2:0] STAT_NEWER     = 3'd0;
    localparam logic [2:0] STAT_OLDER     = 3'd1;
    localparam logic [2:0] STAT_DUPLICATE = 3'd2;
    localparam logic [2:0] STAT_TOO_OLD   = 3'd3;
    localparam logic [2:0] STAT_BEYOND    = 3'd4;

    // Result kinds
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // Shared arithmetic unit operations
    typedef enum logic {
        ALU_SUB,
        ALU_INC
    } alu_op_t;

    typedef struct packed {
        logic             kind;
        logic [2:0]       status;
        logic [SEQ_W-1:0] ack_seq;
        logic [ACK_W-1:0] ack_field;
        logic [SEQ_W-1:0] deliver_seq;
        logic             last;
    } res_t;

endpackage

// ===== hw/rtl/rsaw_alu.sv =====
`timescale 1ns / 1ps

// Shared 16-bit unit: wrap-around difference or increment.
module rsaw_alu (
    input  rsaw_pkg::alu_op_t                op,
    input  logic [rsaw_pkg::SEQ_W-1:0]       a,
    input  logic [rsaw_pkg::SEQ_W-1:0]       b,
    output logic [rsaw_pkg::SEQ_W-1:0]       y
);
    import rsaw_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_SUB: y = a - b;
            ALU_INC: y = a + SEQ_W'(1);
            default: y = a - b;
        endcase
    end

endmodule

// ===== hw/rtl/rsaw_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer: classifies one sequence, updates window state, then releases
// in-order sequences one per cycle while the output accepts them, through the shared unit.
module rsaw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rsaw_pkg::SEQ_W-1:0]    in_seq,
    output logic                          res_valid,
    input  logic                          res_ready,
    output rsaw_pkg::res_t                res
);
    import rsaw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF_D,
        ST_DIFF_R,
        ST_UPDATE,
        ST_STATUS,
        ST_RELEASE
    } state_t;

    state_t                 state_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic [SEQ_W-1:0]       dd_reg;
    logic [SEQ_W-1:0]       dr_reg;
    logic [SEQ_W-1:0]       remote_reg;
    logic [ACK_W-1:0]       field_reg;
    logic [SEQ_W-1:0]       deliv_reg;
    logic [HOLD_WINDOW-1:0] pend_reg;
    logic [2:0]             status_reg;
    logic                   last_reg;

    alu_op_t          alu_op;
    logic [SEQ_W-1:0] alu_a;
    logic [SEQ_W-1:0] alu_b;
    logic [SEQ_W-1:0] alu_y;

    rsaw_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    always_comb
    begin
        alu_op = ALU_SUB;
        alu_a  = seq_reg;
        alu_b  = deliv_reg;
        unique case (state_reg)
            ST_DIFF_R:
            begin
                alu_b = remote_reg;
            end
            ST_RELEASE:
            begin
                alu_op = ALU_INC;
                alu_a  = deliv_reg;
            end
            default:
            begin
                alu_b = deliv_reg;
            end
        endcase
    end

    // Classification and update
    logic [IDX_W-1:0]       pidx;
    logic                   in_win;
    logic                   held;
    logic                   accepted;
    logic [2:0]             status_next;
    logic [HOLD_WINDOW-1:0] pend_next;
    logic [SEQ_W-1:0]       remote_next;
    logic [ACK_W-1:0]       field_next;
    logic [ACK_W:0]         shifted;
    logic [SEQ_W-1:0]       dr_m1;
    logic [SEQ_W-1:0]       dr_inv;

    always_comb
    begin
        pidx        = dd_reg[IDX_W-1:0] - IDX_W'(1);
        in_win      = ($signed(dd_reg) > $signed(SEQ_W'(0))) &&
                      ($signed(dd_reg) <= HOLD_WINDOW_S);
        held        = in_win && pend_reg[pidx];
        accepted    = 1'b0;
        pend_next   = pend_reg;
        remote_next = remote_reg;
        field_next  = field_reg;
        dr_m1       = dr_reg - SEQ_W'(1);
        dr_inv      = ~dr_reg;
        // {field,1} << (d-1) yields field<<d with bit d-1 set
        shifted     = {field_reg, 1'b1} << dr_m1[IDX_W-1:0];
        priority if (held || !($signed(dd_reg) > $signed(SEQ_W'(0))))
        begin
            status_next = STAT_DUPLICATE;
        end
        else if ($signed(dr_reg) < TOO_OLD_S)
        begin
            status_next = STAT_TOO_OLD;
        end
        else if ($signed(dd_reg) > HOLD_WINDOW_S)
        begin
            status_next = STAT_BEYOND;
        end
        else
        begin
            accepted  = 1'b1;
            pend_next = pend_reg | ({{(HOLD_WINDOW-1){1'b0}}, 1'b1} << pidx);
            if ($signed(dr_reg) > $signed(SEQ_W'(0)))
            begin
                status_next = STAT_NEWER;
                remote_next = seq_reg;
                if ($signed(dr_reg) <= $signed(SEQ_W'(ACK_W)))
                begin
                    field_next = shifted[ACK_W-1:0];
                end
                else
                begin
                    field_next = '0;
                end
            end
            else
            begin
                status_next = STAT_OLDER;
                // -d-1 == ~d; d >= -32 here, so the index stays in range
                if (dr_reg != '0)
                begin
                    field_next = field_reg |
                                 ({{(ACK_W-1){1'b0}}, 1'b1} << dr_inv[$clog2(ACK_W)-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remote_reg <= '0;
            field_reg  <= '0;
            deliv_reg  <= '0;
            pend_reg   <= '0;
            status_reg <= STAT_NEWER;
            last_reg   <= 1'b0;
            seq_reg    <= '0;
            dd_reg     <= '0;
            dr_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        seq_reg   <= in_seq;
                        state_reg <= ST_DIFF_D;
                    end
                end
                ST_DIFF_D:
                begin
                    dd_reg    <= alu_y;
                    state_reg <= ST_DIFF_R;
                end
                ST_DIFF_R:
                begin
                    dr_reg    <= alu_y;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    status_reg <= status_next;
                    pend_reg   <= pend_next;
                    remote_reg <= remote_next;
                    field_reg  <= field_next;
                    last_reg   <= !(accepted && pend_next[0]);
                    state_reg  <= ST_STATUS;
                end
                ST_STATUS:
                begin
                    if (res_ready)
                    begin
                        state_reg <= last_reg ? ST_IDLE : ST_RELEASE;
                    end
                end
                ST_RELEASE:
                begin
                    if (res_ready)
                    begin
                        deliv_reg <= alu_y;
                        pend_reg  <= pend_reg >> 1;
                        if (!pend_reg[1])
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_STATUS) || (state_reg == ST_RELEASE);

    always_comb
    begin
        res.ack_seq   = remote_reg;
        res.ack_field = field_reg;
        if (state_reg == ST_RELEASE)
        begin
            res.kind        = KIND_DELIVER;
            res.status      = STAT_NEWER;
            res.deliver_seq = alu_y;
            res.last        = !pend_reg[1];
        end
        else
        begin
            res.kind        = KIND_STATUS;
            res.status      = status_reg;
            res.deliver_seq = '0;
            res.last        = last_reg;
        end
    end

endmodule

// ===== hw/rtl/receive_sequence_ack_window.sv =====
`timescale 1ns / 1ps

// The status result passes sequencer states DIFF_D, DIFF_R, UPDATE and STATUS before
// the output register; in-order delivery results follow it unless downstream stalls.
// A new input is taken only when the sequencer is idle, after it has released all
// in-order sequences (0..32), stepping the single shared 16-bit subtract/increment unit.
// Reset (rst_n low, asynchronous): window empty, newest and delivered sequence 0.
module receive_sequence_ack_window (
    input  logic        clk,
    input  logic        rst_n,
    // Received sequence numbers
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] seq_in
    // Status and delivery results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [2:0] status, [18:3] ack_seq,
                                        // [50:19] ack_field, [66:51] deliver_seq
    output logic [0:0]  m_axis_tuser,   // [0] kind (0 status, 1 delivery)
    output logic        m_axis_tlast    // final result of an input transaction
);
    import rsaw_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;

    rsaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_seq    (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: decouples the sequencer from downstream stalls
    logic out_valid_reg;
    res_t out_reg;

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.deliver_seq, out_reg.ack_field,
                            out_reg.ack_seq, out_reg.status};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

endmodule
